// ===== design/pecp_pkg.sv =====
`timescale 1ns / 1ps

package pecp_pkg;

    localparam int NODES_DEFAULT = 8;
    localparam int DIMS_DEFAULT  = 2;

    typedef enum logic [2:0] {
        CMD_WRITE_BIT   = 3'd0,
        CMD_WRITE_NODE  = 3'd1,
        CMD_READ_BIT    = 3'd2,
        CMD_OVERLAP     = 3'd3,
        CMD_C4          = 3'd4
    } cmd_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PAIR,
        ST_RULE_A,
        ST_RULE_B,
        ST_RULE_C,
        ST_RULE_M1,
        ST_RULE_M2,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_EXEC,
        OP_PAIR,
        OP_RULE_A,
        OP_RULE_B,
        OP_RULE_C,
        OP_RULE_M1,
        OP_RULE_M2,
        OP_FIN
    } op_t;

    typedef struct packed {
        logic capture;
        op_t  op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic c4_go;
        logic minus;
        logic pair_ok;
        logic last_pair;
        logic exit_hit;
    } dp_status_t;

endpackage

// ===== design/pecp_ctrl.sv =====
`timescale 1ns / 1ps

module pecp_ctrl
    import pecp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t stat,
    output ctrl_cmd_t  cmd_out,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = stat.c4_go ? ST_PAIR : ST_FIN;
            end
            ST_PAIR:
            begin
                if (stat.pair_ok)
                begin
                    state_next = stat.minus ? ST_RULE_M1 : ST_RULE_A;
                end
                else if (stat.last_pair)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RULE_A:
            begin
                state_next = stat.exit_hit ? ST_FIN : ST_RULE_B;
            end
            ST_RULE_B:
            begin
                state_next = stat.exit_hit ? ST_FIN : ST_RULE_C;
            end
            ST_RULE_M1:
            begin
                state_next = stat.exit_hit ? ST_FIN : ST_RULE_M2;
            end
            ST_RULE_C, ST_RULE_M2:
            begin
                priority if (stat.exit_hit || stat.last_pair)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy            = (state_reg != ST_IDLE);
        cmd_out.capture = (state_reg == ST_IDLE) && start;
        unique case (state_reg)
            ST_EXEC:    cmd_out.op = OP_EXEC;
            ST_PAIR:    cmd_out.op = OP_PAIR;
            ST_RULE_A:  cmd_out.op = OP_RULE_A;
            ST_RULE_B:  cmd_out.op = OP_RULE_B;
            ST_RULE_C:  cmd_out.op = OP_RULE_C;
            ST_RULE_M1: cmd_out.op = OP_RULE_M1;
            ST_RULE_M2: cmd_out.op = OP_RULE_M2;
            ST_FIN:     cmd_out.op = OP_FIN;
            default:    cmd_out.op = OP_NONE;
        endcase
    end

endmodule

// ===== design/pecp_datapath.sv =====
`timescale 1ns / 1ps

module pecp_datapath
    import pecp_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT,
    parameter int DIMS  = DIMS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd_in,
    input  logic [2:0] cmd,
    input  logic [1:0] dim_sel,
    input  logic [2:0] edge_i,
    input  logic [2:0] edge_j,
    input  logic       to_minus,
    input  logic       set_select,
    input  logic       bit_value,
    output dp_status_t stat,
    output logic       result_valid,
    output logic       is_augmentation,
    output logic [2:0] aug_i,
    output logic [2:0] aug_j,
    output logic       aug_to_minus,
    output logic [1:0] aug_dim,
    output logic       status,
    output logic       read_bit,
    output logic       last
);

    localparam int ROWS = DIMS * NODES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [2:0] LAST_NODE = 3'(NODES - 1);

    logic [NODES-1:0] pos_reg [ROWS];
    logic [NODES-1:0] neg_reg [ROWS];
    logic [NODES-1:0] present_reg;

    logic [2:0] cmd_reg;
    logic [1:0] dim_reg;
    logic [2:0] i_reg;
    logic [2:0] j_reg;
    logic       minus_reg;
    logic       sel_reg;
    logic       val_reg;
    logic [2:0] k_reg;
    logic [2:0] l_reg;
    logic       status_reg;
    logic       rbit_reg;

    logic       valid_reg;
    logic       aug_reg;
    logic [2:0] ai_reg;
    logic [2:0] aj_reg;
    logic       am_reg;
    logic [1:0] ad_reg;
    logic       ost_reg;
    logic       orb_reg;
    logic       last_reg;

    function automatic logic [RW-1:0] row_idx(input logic [1:0] d, input logic [2:0] a);
        int r;
        r = int'(d) * NODES + int'(a);
        return r[RW-1:0];
    endfunction

    logic nodes_ok;
    logic dim_ok;
    assign nodes_ok = (int'(i_reg) < NODES) && (int'(j_reg) < NODES);
    assign dim_ok   = int'(dim_reg) < DIMS;

    logic [NW-1:0] i_col;
    logic [NW-1:0] j_col;
    logic [NW-1:0] k_col;
    logic [NW-1:0] l_col;
    assign i_col = i_reg[NW-1:0];
    assign j_col = j_reg[NW-1:0];
    assign k_col = k_reg[NW-1:0];
    assign l_col = l_reg[NW-1:0];

    logic       wr_en;
    logic       wr_neg;
    logic       wr_val;
    logic [1:0] wr_dim;
    logic [2:0] wr_a;
    logic [2:0] wr_b;
    logic       emit;
    logic       emit_minus;
    logic       exit_hit;
    logic       rd_bit;
    logic       pres_wr;

    logic [2:0] free_n;
    logic [1:0] free_d;
    logic [2:0] miss;
    logic [2:0] ma;
    logic [2:0] mb;
    logic [2:0] ik;
    logic [2:0] jl;
    logic [2:0] nik;
    logic [2:0] njl;

    always_comb
    begin
        wr_en      = 1'b0;
        wr_neg     = 1'b0;
        wr_val     = 1'b1;
        wr_dim     = dim_reg;
        wr_a       = i_reg;
        wr_b       = j_reg;
        emit       = 1'b0;
        emit_minus = 1'b0;
        exit_hit   = 1'b0;
        rd_bit     = 1'b0;
        pres_wr    = 1'b0;
        free_n     = '0;
        free_d     = '0;
        miss       = '0;
        ma         = '0;
        mb         = '0;
        ik         = '0;
        jl         = '0;
        nik        = '0;
        njl        = '0;
        unique case (cmd_in.op)
            OP_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_WRITE_BIT:
                    begin
                        wr_en  = nodes_ok && dim_ok;
                        wr_neg = sel_reg;
                        wr_val = val_reg;
                    end
                    CMD_WRITE_NODE:
                    begin
                        pres_wr = int'(i_reg) < NODES;
                    end
                    CMD_READ_BIT:
                    begin
                        if (nodes_ok && dim_ok)
                        begin
                            rd_bit = sel_reg ? neg_reg[row_idx(dim_reg, i_reg)][j_col]
                                             : pos_reg[row_idx(dim_reg, i_reg)][j_col];
                        end
                    end
                    CMD_OVERLAP:
                    begin
                        for (int d = 0; d < DIMS; d++)
                        begin
                            if (!pos_reg[row_idx(2'(d), i_reg)][j_col])
                            begin
                                free_n = free_n + 3'd1;
                                free_d = 2'(d);
                            end
                        end
                        if (nodes_ok && !minus_reg)
                        begin
                            exit_hit   = (free_n == 3'd0);
                            wr_en      = (free_n == 3'd1);
                            wr_neg     = 1'b1;
                            wr_dim     = free_d;
                            emit       = wr_en;
                            emit_minus = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_RULE_A, OP_RULE_B, OP_RULE_C:
            begin
                if (!pos_reg[row_idx(dim_reg, j_reg)][k_col])
                begin
                    miss = miss + 3'd1; ma = j_reg; mb = k_reg;
                end
                if (!pos_reg[row_idx(dim_reg, k_reg)][l_col])
                begin
                    miss = miss + 3'd1; ma = k_reg; mb = l_reg;
                end
                if (!pos_reg[row_idx(dim_reg, l_reg)][i_col])
                begin
                    miss = miss + 3'd1; ma = l_reg; mb = i_reg;
                end
                ik  = {2'b00, pos_reg[row_idx(dim_reg, i_reg)][k_col]};
                jl  = {2'b00, pos_reg[row_idx(dim_reg, j_reg)][l_col]};
                nik = {2'b00, neg_reg[row_idx(dim_reg, i_reg)][k_col]};
                njl = {2'b00, neg_reg[row_idx(dim_reg, j_reg)][l_col]};
                if (cmd_in.op == OP_RULE_A)
                begin
                    if (nik[0] && njl[0])
                    begin
                        exit_hit = (miss == 3'd0);
                        if (miss == 3'd1 && !neg_reg[row_idx(dim_reg, ma)][mb[NW-1:0]])
                        begin
                            wr_en = 1'b1; wr_neg = 1'b1; wr_a = ma; wr_b = mb;
                            emit = 1'b1; emit_minus = 1'b1;
                        end
                    end
                end
                else if (cmd_in.op == OP_RULE_B)
                begin
                    if (nik[0] && !jl[0] && miss == 3'd0)
                    begin
                        exit_hit = njl[0];
                        wr_en = !njl[0]; wr_a = j_reg; wr_b = l_reg; emit = !njl[0];
                    end
                end
                else
                begin
                    if (njl[0] && !ik[0] && miss == 3'd0)
                    begin
                        exit_hit = nik[0];
                        wr_en = !nik[0]; wr_a = i_reg; wr_b = k_reg; emit = !nik[0];
                    end
                end
            end
            OP_RULE_M1, OP_RULE_M2:
            begin
                if (!pos_reg[row_idx(dim_reg, i_reg)][k_col])
                begin
                    miss = miss + 3'd1; ma = i_reg; mb = k_reg;
                end
                if (!pos_reg[row_idx(dim_reg, k_reg)][j_col])
                begin
                    miss = miss + 3'd1; ma = k_reg; mb = j_reg;
                end
                if (!pos_reg[row_idx(dim_reg, j_reg)][l_col])
                begin
                    miss = miss + 3'd1; ma = j_reg; mb = l_reg;
                end
                if (!pos_reg[row_idx(dim_reg, l_reg)][i_col])
                begin
                    miss = miss + 3'd1; ma = l_reg; mb = i_reg;
                end
                if (cmd_in.op == OP_RULE_M1)
                begin
                    if (neg_reg[row_idx(dim_reg, k_reg)][l_col])
                    begin
                        exit_hit = (miss == 3'd0);
                        if (miss == 3'd1)
                        begin
                            wr_en = 1'b1; wr_neg = 1'b1; wr_a = ma; wr_b = mb;
                            emit = 1'b1; emit_minus = 1'b1;
                        end
                    end
                end
                else if (miss == 3'd0 && !pos_reg[row_idx(dim_reg, k_reg)][l_col])
                begin
                    exit_hit = neg_reg[row_idx(dim_reg, k_reg)][l_col];
                    wr_en = !exit_hit; wr_a = k_reg; wr_b = l_reg; emit = !exit_hit;
                end
            end
            default:
            begin
            end
        endcase
    end

    logic pair_ok;
    logic last_pair;
    logic advance;
    assign pair_ok = present_reg[k_col] && present_reg[l_col]
                     && (k_reg != i_reg) && (k_reg != j_reg)
                     && (l_reg != i_reg) && (l_reg != j_reg) && (l_reg != k_reg);
    assign last_pair = (k_reg == LAST_NODE) && (l_reg == LAST_NODE);
    assign advance = ((cmd_in.op == OP_PAIR) && !pair_ok)
                     || (((cmd_in.op == OP_RULE_C) || (cmd_in.op == OP_RULE_M2)) && !exit_hit);

    always_comb
    begin
        stat.c4_go     = (cmd_reg == CMD_C4) && nodes_ok && dim_ok;
        stat.minus     = minus_reg;
        stat.pair_ok   = pair_ok;
        stat.last_pair = last_pair;
        stat.exit_hit  = exit_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '{default: '0};
            neg_reg     <= '{default: '0};
            present_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_neg)
                begin
                    neg_reg[row_idx(wr_dim, wr_a)][wr_b[NW-1:0]] <= wr_val;
                    neg_reg[row_idx(wr_dim, wr_b)][wr_a[NW-1:0]] <= wr_val;
                end
                else
                begin
                    pos_reg[row_idx(wr_dim, wr_a)][wr_b[NW-1:0]] <= wr_val;
                    pos_reg[row_idx(wr_dim, wr_b)][wr_a[NW-1:0]] <= wr_val;
                end
            end
            if (pres_wr)
            begin
                present_reg[i_col] <= val_reg;
            end
            valid_reg <= emit || (cmd_in.op == OP_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_in.capture)
        begin
            cmd_reg    <= cmd;
            dim_reg    <= dim_sel;
            i_reg      <= edge_i;
            j_reg      <= edge_j;
            minus_reg  <= to_minus;
            sel_reg    <= set_select;
            val_reg    <= bit_value;
            k_reg      <= '0;
            l_reg      <= '0;
            status_reg <= 1'b0;
            rbit_reg   <= 1'b0;
        end
        else
        begin
            if (exit_hit)
            begin
                status_reg <= 1'b1;
            end
            if (cmd_in.op == OP_EXEC)
            begin
                rbit_reg <= rd_bit;
            end
            if (advance)
            begin
                if (l_reg == LAST_NODE)
                begin
                    l_reg <= '0;
                    k_reg <= k_reg + 3'd1;
                end
                else
                begin
                    l_reg <= l_reg + 3'd1;
                end
            end
        end
        if (emit)
        begin
            aug_reg  <= 1'b1;
            ai_reg   <= wr_a;
            aj_reg   <= wr_b;
            am_reg   <= emit_minus;
            ad_reg   <= wr_dim;
            ost_reg  <= 1'b0;
            orb_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            aug_reg  <= 1'b0;
            ai_reg   <= '0;
            aj_reg   <= '0;
            am_reg   <= 1'b0;
            ad_reg   <= '0;
            ost_reg  <= status_reg;
            orb_reg  <= rbit_reg;
            last_reg <= 1'b1;
        end
    end

    assign result_valid    = valid_reg;
    assign is_augmentation = aug_reg;
    assign aug_i           = ai_reg;
    assign aug_j           = aj_reg;
    assign aug_to_minus    = am_reg;
    assign aug_dim         = ad_reg;
    assign status          = ost_reg;
    assign read_bit        = orb_reg;
    assign last            = last_reg;

endmodule

// ===== design/packing_edge_constraint_propagator_core.sv =====
`timescale 1ns / 1ps
// Edge constraint propagator for a packing search.
// A request is taken at a rising edge with start high and busy low; the
// fields cmd, dim_sel, edge_i, edge_j, to_minus, set_select and bit_value
// are sampled there. Busy stays high until the closing result is on the ports.
// Results appear one per cycle for exactly one cycle, marked by result_valid.
// Each derived edge of a check is one result with is_augmentation set; every
// request ends with a closing result that carries status, read_bit and last.
// Write, read and overlap requests pass through the EXEC and FIN states before
// the closing result, and the next request may be taken at the edge that ends it.
// A C4 check visits each of the NODES*NODES ordered node pairs in the
// PAIR state and runs rules A, B and C (M1 and M2 for a negative target) on
// each usable pair, one rule per cycle, before the closing result. An EXIT
// ends the walk at once.
// The receiver cannot stall; results are never held.
// Reset clears both edge matrices, the node mask, result_valid and the controller state.

module packing_edge_constraint_propagator_core
    import pecp_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT,
    parameter int DIMS  = DIMS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] cmd,
    input  logic [1:0] dim_sel,
    input  logic [2:0] edge_i,
    input  logic [2:0] edge_j,
    input  logic       to_minus,
    input  logic       set_select,
    input  logic       bit_value,
    output logic       result_valid,
    output logic       is_augmentation,
    output logic [2:0] aug_i,
    output logic [2:0] aug_j,
    output logic       aug_to_minus,
    output logic [1:0] aug_dim,
    output logic       status,
    output logic       read_bit,
    output logic       last
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_stat;

    pecp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .stat    (dp_stat),
        .cmd_out (ctrl_cmd),
        .busy    (busy)
    );

    pecp_datapath #(
        .NODES (NODES),
        .DIMS  (DIMS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_in          (ctrl_cmd),
        .cmd             (cmd),
        .dim_sel         (dim_sel),
        .edge_i          (edge_i),
        .edge_j          (edge_j),
        .to_minus        (to_minus),
        .set_select      (set_select),
        .bit_value       (bit_value),
        .stat            (dp_stat),
        .result_valid    (result_valid),
        .is_augmentation (is_augmentation),
        .aug_i           (aug_i),
        .aug_j           (aug_j),
        .aug_to_minus    (aug_to_minus),
        .aug_dim         (aug_dim),
        .status          (status),
        .read_bit        (read_bit),
        .last            (last)
    );

endmodule

// ===== tb/packing_edge_constraint_propagator_core_test.sv =====
`timescale 1ns / 1ps

module packing_edge_constraint_propagator_core_test;
    import pecp_pkg::*;

    localparam int NN = 8;
    localparam int ND = 2;
    localparam int RANDOM_REQUESTS = 106;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] dim;
        logic [2:0] ei;
        logic [2:0] ej;
        logic       minus;
        logic       sel;
        logic       val;
    } request_t;

    localparam int REQ_W = $bits(request_t);

    typedef struct packed {
        logic       aug;
        logic [2:0] ai;
        logic [2:0] aj;
        logic       am;
        logic [1:0] ad;
        logic       st;
        logic       rb;
        logic       lst;
    } answer_t;

    // Known answer: has_known means the row's closing result is typed in.
    typedef struct packed {
        request_t req;
        logic     has_known;
        logic     known_st;
        logic     known_rb;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] cmd;
    logic [1:0] dim_sel;
    logic [2:0] edge_i;
    logic [2:0] edge_j;
    logic to_minus;
    logic set_select;
    logic bit_value;
    logic result_valid;
    logic is_augmentation;
    logic [2:0] aug_i;
    logic [2:0] aug_j;
    logic aug_to_minus;
    logic [1:0] aug_dim;
    logic status;
    logic read_bit;
    logic last;

    logic pos_edges [ND][NN][NN];
    logic neg_edges [ND][NN][NN];
    logic present [NN];
    answer_t pending_answers [$];
    int errors;
    int answers_seen;
    int augments_seen;
    int exits_seen;
    longint cycles;

    packing_edge_constraint_propagator_core #(.NODES(NN), .DIMS(ND)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .dim_sel(dim_sel), .edge_i(edge_i), .edge_j(edge_j), .to_minus(to_minus),
        .set_select(set_select), .bit_value(bit_value), .result_valid(result_valid),
        .is_augmentation(is_augmentation), .aug_i(aug_i), .aug_j(aug_j),
        .aug_to_minus(aug_to_minus), .aug_dim(aug_dim), .status(status),
        .read_bit(read_bit), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void expect_answer(answer_t a);
        pending_answers.insert(pending_answers.size(), a);
    endfunction

    function automatic answer_t derived_edge(int a, int b, logic m, int d);
        answer_t r;
        r = '0;
        r.aug = 1'b1;
        r.ai = a[2:0];
        r.aj = b[2:0];
        r.am = m;
        r.ad = d[1:0];
        return r;
    endfunction

    function automatic logic overlap_edges(int i, int j, logic m);
        int free_n;
        int free_d;
        free_n = 0;
        free_d = 0;
        if (m)
            return 1'b0;
        for (int d = 0; d < ND; d++)
        begin
            if (!pos_edges[d][i][j])
            begin
                free_d = d;
                free_n++;
            end
        end
        if (free_n == 0)
            return 1'b1;
        if (free_n == 1)
        begin
            neg_edges[free_d][i][j] = 1'b1;
            neg_edges[free_d][j][i] = 1'b1;
            expect_answer(derived_edge(i, j, 1'b1, free_d));
        end
        return 1'b0;
    endfunction

    function automatic void mark(logic is_neg, int d, int a, int b, logic m);
        if (is_neg)
        begin
            neg_edges[d][a][b] = 1'b1;
            neg_edges[d][b][a] = 1'b1;
        end
        else
        begin
            pos_edges[d][a][b] = 1'b1;
            pos_edges[d][b][a] = 1'b1;
        end
        expect_answer(derived_edge(a, b, m, d));
    endfunction

    function automatic logic four_cycle_edges(int i, int j, logic m, int d);
        int miss;
        int ma;
        int mb;
        for (int k = 0; k < NN; k++)
        begin
            if (!present[k] || k == i || k == j)
                continue;
            for (int l = 0; l < NN; l++)
            begin
                if (!present[l] || l == i || l == j || l == k)
                    continue;
                miss = 0;
                ma = 0;
                mb = 0;
                if (!m)
                begin
                    if (!pos_edges[d][j][k]) begin miss++; ma = j; mb = k; end
                    if (!pos_edges[d][k][l]) begin miss++; ma = k; mb = l; end
                    if (!pos_edges[d][l][i]) begin miss++; ma = l; mb = i; end
                    if (neg_edges[d][i][k] && neg_edges[d][j][l])
                    begin
                        if (miss == 0)
                            return 1'b1;
                        if (miss == 1 && !neg_edges[d][ma][mb])
                            mark(1'b1, d, ma, mb, 1'b1);
                    end
                    if (neg_edges[d][i][k] && !pos_edges[d][j][l] && miss == 0)
                    begin
                        if (neg_edges[d][j][l])
                            return 1'b1;
                        mark(1'b0, d, j, l, 1'b0);
                    end
                    if (neg_edges[d][j][l] && !pos_edges[d][i][k] && miss == 0)
                    begin
                        if (neg_edges[d][i][k])
                            return 1'b1;
                        mark(1'b0, d, i, k, 1'b0);
                    end
                end
                else
                begin
                    if (!pos_edges[d][i][k]) begin miss++; ma = i; mb = k; end
                    if (!pos_edges[d][k][j]) begin miss++; ma = k; mb = j; end
                    if (!pos_edges[d][j][l]) begin miss++; ma = j; mb = l; end
                    if (!pos_edges[d][l][i]) begin miss++; ma = l; mb = i; end
                    if (neg_edges[d][k][l])
                    begin
                        if (miss == 0)
                            return 1'b1;
                        if (miss == 1)
                            mark(1'b1, d, ma, mb, 1'b1);
                    end
                    if (miss == 0 && !pos_edges[d][k][l])
                    begin
                        if (neg_edges[d][k][l])
                            return 1'b1;
                        mark(1'b0, d, k, l, 1'b0);
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic answer_t predict_request(request_t q);
        answer_t fin;
        int i;
        int j;
        int d;
        logic ok;
        fin = '0;
        fin.lst = 1'b1;
        i = q.ei;
        j = q.ej;
        d = q.dim;
        ok = (d < ND);
        case (q.cmd)
            CMD_WRITE_BIT:
                if (ok)
                begin
                    if (q.sel)
                    begin
                        neg_edges[d][i][j] = q.val;
                        neg_edges[d][j][i] = q.val;
                    end
                    else
                    begin
                        pos_edges[d][i][j] = q.val;
                        pos_edges[d][j][i] = q.val;
                    end
                end
            CMD_WRITE_NODE:
                present[i] = q.val;
            CMD_READ_BIT:
                if (ok)
                    fin.rb = q.sel ? neg_edges[d][i][j] : pos_edges[d][i][j];
            CMD_OVERLAP:
                fin.st = overlap_edges(i, j, q.minus);
            CMD_C4:
                if (ok)
                    fin.st = four_cycle_edges(i, j, q.minus, d);
            default:
                ;
        endcase
        expect_answer(fin);
        return fin;
    endfunction

    // Start stays high across a zero gap so that it is assigned once per edge.
    task automatic send_request(request_t q);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= q.cmd;
        dim_sel <= q.dim;
        edge_i <= q.ei;
        edge_j <= q.ej;
        to_minus <= q.minus;
        set_select <= q.sel;
        bit_value <= q.val;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic request_t make_req(cmd_code_t c, int d, int i, int j,
                                          logic m, logic s, logic v);
        request_t q;
        q.cmd = c;
        q.dim = d[1:0];
        q.ei = i[2:0];
        q.ej = j[2:0];
        q.minus = m;
        q.sel = s;
        q.val = v;
        return q;
    endfunction

    function automatic request_t random_request();
        request_t q;
        logic [REQ_W-1:0] raw;
        int pick;
        raw = REQ_W'($urandom);
        q = raw;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            q.cmd = CMD_WRITE_BIT;
        else if (pick < 40)
            q.cmd = CMD_WRITE_NODE;
        else if (pick < 52)
            q.cmd = CMD_READ_BIT;
        else if (pick < 66)
            q.cmd = CMD_OVERLAP;
        else if (pick < 95)
            q.cmd = CMD_C4;
        if (pick < 95 && $urandom_range(0, 7) != 0)
            q.dim = 2'($urandom_range(0, ND - 1));
        if (q.cmd == CMD_WRITE_BIT && $urandom_range(0, 2) != 0)
            q.val = 1'b1;
        if (q.cmd == CMD_WRITE_NODE && $urandom_range(0, 3) != 0)
            q.val = 1'b1;
        return q;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result_valid)
        begin
            answers_seen <= answers_seen + 1;
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result aug=%0d last=%0d", is_augmentation, last);
                errors <= errors + 1;
            end
            else
            begin
                answer_t e;
                e = pending_answers.pop_front();
                if (is_augmentation) augments_seen <= augments_seen + 1;
                if (last && status) exits_seen <= exits_seen + 1;
                if (e.aug !== is_augmentation)
                    $error("is_augmentation expected %0d actual %0d", e.aug, is_augmentation);
                if (e.ai !== aug_i)
                    $error("aug_i expected %0d actual %0d", e.ai, aug_i);
                if (e.aj !== aug_j)
                    $error("aug_j expected %0d actual %0d", e.aj, aug_j);
                if (e.am !== aug_to_minus)
                    $error("aug_to_minus expected %0d actual %0d", e.am, aug_to_minus);
                if (e.ad !== aug_dim)
                    $error("aug_dim expected %0d actual %0d", e.ad, aug_dim);
                if (e.st !== status)
                    $error("status expected %0d actual %0d", e.st, status);
                if (e.rb !== read_bit)
                    $error("read_bit expected %0d actual %0d", e.rb, read_bit);
                if (e.lst !== last)
                    $error("last expected %0d actual %0d", e.lst, last);
                if (e !== {is_augmentation, aug_i, aug_j, aug_to_minus, aug_dim,
                           status, read_bit, last})
                    errors <= errors + 1;
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("packing_edge_constraint_propagator_core_test failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        request_t q;
        answer_t fin;
        errors = 0;
        answers_seen = 0;
        augments_seen = 0;
        exits_seen = 0;
        cycles = 0;
        foreach (pos_edges[d, a, b])
        begin
            pos_edges[d][a][b] = 1'b0;
            neg_edges[d][a][b] = 1'b0;
        end
        foreach (present[a])
            present[a] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        dim_sel = '0;
        edge_i = '0;
        edge_j = '0;
        to_minus = 1'b0;
        set_select = 1'b0;
        bit_value = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.insert(rows.size(), {make_req(CMD_READ_BIT, 1, 7, 7, 0, 1, 0), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_OVERLAP, 0, 2, 5, 0, 0, 0), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_OVERLAP, 0, 2, 5, 1, 0, 0), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_WRITE_BIT, 0, 7, 0, 0, 0, 1), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_READ_BIT, 0, 0, 7, 0, 0, 0), 1'b1, 1'b0, 1'b1});
        rows.insert(rows.size(), {make_req(CMD_WRITE_BIT, 1, 7, 0, 0, 0, 1), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_OVERLAP, 3, 0, 7, 0, 0, 0), 1'b1, 1'b1, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_WRITE_BIT, 3, 1, 2, 0, 0, 1), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_READ_BIT, 2, 1, 2, 0, 0, 0), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_C4, 3, 1, 2, 0, 0, 0), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(),
                    {request_t'({3'd7, 2'd3, 3'd7, 3'd7, 3'b111}), 1'b1, 1'b0, 1'b0});
        rows.insert(rows.size(),
                    {request_t'({3'd5, 2'd0, 3'd0, 3'd0, 3'b000}), 1'b1, 1'b0, 1'b0});
        for (int n = 0; n < 6; n++)
            rows.insert(rows.size(),
                        {make_req(CMD_WRITE_NODE, 0, n, 0, 0, 0, 1), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_WRITE_BIT, 0, 0, 2, 0, 1, 1), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_WRITE_BIT, 0, 1, 3, 0, 1, 1), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_C4, 0, 0, 1, 0, 0, 0), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_C4, 0, 0, 1, 1, 0, 0), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_C4, 0, 2, 3, 1, 0, 0), 1'b0, 1'b0, 1'b0});
        rows.insert(rows.size(), {make_req(CMD_C4, 0, 4, 5, 0, 0, 0), 1'b0, 1'b0, 1'b0});

        foreach (rows[r])
        begin
            fin = predict_request(rows[r].req);
            if (rows[r].has_known && (fin.st !== rows[r].known_st
                                      || fin.rb !== rows[r].known_rb))
            begin
                $error("row %0d status expected %0d actual %0d", r, rows[r].known_st, fin.st);
                errors++;
            end
            send_request(rows[r].req);
        end
        drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            q = random_request();
            void'(predict_request(q));
            send_request(q);
            if (n == RANDOM_REQUESTS / 2)
                drain();
        end
        drain();

        $display("Covered %0d results, %0d derived edges, %0d exits.",
                 answers_seen, augments_seen, exits_seen);
        if (errors == 0 && pending_answers.size() == 0)
            $display("packing_edge_constraint_propagator_core_test passed");
        else
            $display("packing_edge_constraint_propagator_core_test failed");
        $finish;
    end

endmodule

// ===== packing_edge_constraint_propagator_core.f =====
design/pecp_pkg.sv
design/pecp_ctrl.sv
design/pecp_datapath.sv
design/packing_edge_constraint_propagator_core.sv
tb/packing_edge_constraint_propagator_core_test.sv
